[rtl/ttce_pkg.sv]
`default_nettype none

package ttce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PTR_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int TAB_STOP   = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [COL_W:0]    wcol_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [1:0]        action_t;
    typedef logic [7:0]        char_t;
    typedef logic [10:0]       index_t;
    typedef logic [10:0]       cursor_t;
    typedef logic [15:0]       cell_t;

    localparam action_t ACT_PUT   = 2'd0;
    localparam action_t ACT_CLEAR = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    localparam char_t CH_BS        = 8'h08;
    localparam char_t CH_TAB       = 8'h09;
    localparam char_t CH_LF        = 8'h0A;
    localparam char_t CH_CR        = 8'h0D;
    localparam char_t CH_SPACE     = 8'h20;
    localparam char_t CH_PRINT_MAX = 8'h7F;

    localparam char_t RESET_ATTR  = 8'h02;
    localparam cell_t RESET_BLANK = {RESET_ATTR, CH_SPACE};

    typedef struct packed {
        col_t  col;
        row_t  row;
        addr_t base;
        logic  wr_en;
        addr_t wr_addr;
        cell_t wr_data;
        logic  scroll;
    } step_t;

endpackage

`default_nettype wire

[rtl/text_terminal_char_engine_unit.sv]
`default_nettype none

// Character-cell text console with an 80 x 25 store of 16-bit cells (attribute high,
// character low) in a single-port-write, single-port-read memory and a cursor. A put,
// read or unused-action transfer is accepted and issues its cell access in S_IDLE, then
// loads the result register in S_DONE. A clear, and any put that scrolls the screen, sweeps
// the whole store through its one read and one write port, one cell a cycle, in S_SWEEP.
// After reset a clearing pass in S_INIT runs with in_stall high; attribute writes are
// taken at any time. A new transfer is taken while the previous result still waits on
// out_stall.

module text_terminal_char_engine_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire ttce_pkg::char_t  cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ttce_pkg::action_t action,
    input  wire ttce_pkg::char_t  char_code,
    input  wire ttce_pkg::index_t cell_index,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ttce_pkg::cursor_t     cursor_index,
    output ttce_pkg::cell_t       cell_data
);

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    ttce_pkg::ptr_t    ptr_reg, ptr_next;
    logic              scroll_reg, scroll_next;
    logic              wr_en_reg, wr_en_next;
    logic              wr_copy_reg, wr_copy_next;
    ttce_pkg::addr_t   wr_addr_reg, wr_addr_next;
    ttce_pkg::cell_t   wr_data_reg, wr_data_next;
    logic              read_hit_reg, read_hit_next;
    ttce_pkg::col_t    col_reg, col_next;
    ttce_pkg::row_t    row_reg, row_next;
    ttce_pkg::addr_t   base_reg, base_next;
    ttce_pkg::char_t   attr_reg;
    logic              out_valid_reg, out_valid_next;
    ttce_pkg::cursor_t cursor_index_reg, cursor_index_next;
    ttce_pkg::cell_t   cell_data_reg, cell_data_next;

    logic              rd_en;
    ttce_pkg::addr_t   rd_addr;
    ttce_pkg::cell_t   rd_data;
    ttce_pkg::cell_t   store_wr_data;
    ttce_pkg::cell_t   blank;
    ttce_pkg::ptr_t    src_ptr;
    ttce_pkg::addr_t   cursor_sum;
    ttce_pkg::step_t   step;
    logic              accept;

    assign in_stall      = (state_reg != S_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign cursor_index  = cursor_index_reg;
    assign cell_data     = cell_data_reg;
    assign store_wr_data = wr_copy_reg ? rd_data : wr_data_reg;
    assign src_ptr       = ptr_reg + ttce_pkg::ptr_t'(ttce_pkg::COLUMNS);
    assign cursor_sum    = base_reg + ttce_pkg::addr_t'(col_reg);

    ttce_cell_store u_store (
        .clk     (clk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (store_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ttce_cursor_step u_step (
        .col       (col_reg),
        .row       (row_reg),
        .base      (base_reg),
        .char_code (char_code),
        .attr      (attr_reg),
        .step      (step)
    );

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        scroll_next       = scroll_reg;
        wr_en_next        = 1'b0;
        wr_copy_next      = 1'b0;
        wr_addr_next      = wr_addr_reg;
        wr_data_next      = wr_data_reg;
        read_hit_next     = read_hit_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        base_next         = base_reg;
        out_valid_next    = out_valid_reg && out_stall;
        cursor_index_next = cursor_index_reg;
        cell_data_next    = cell_data_reg;
        rd_en             = 1'b0;
        rd_addr           = ttce_pkg::addr_t'(cell_index);
        blank             = (state_reg == S_INIT) ? ttce_pkg::RESET_BLANK
                                                  : {attr_reg, ttce_pkg::CH_SPACE};

        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                if (ptr_reg != ttce_pkg::ptr_t'(ttce_pkg::CELL_COUNT))
                begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = ptr_reg[ttce_pkg::ADDR_W-1:0];
                    wr_data_next = blank;
                    if (scroll_reg && ptr_reg < ttce_pkg::ptr_t'(ttce_pkg::MOVE_COUNT))
                    begin
                        wr_copy_next = 1'b1;
                        rd_en        = 1'b1;
                        rd_addr      = src_ptr[ttce_pkg::ADDR_W-1:0];
                    end
                    ptr_next = ptr_reg + ttce_pkg::ptr_t'(1);
                end
                else if (state_reg == S_SWEEP)
                begin
                    scroll_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (!wr_en_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    read_hit_next = 1'b0;
                    state_next    = S_DONE;
                    case (action)
                        ttce_pkg::ACT_PUT:
                        begin
                            col_next     = step.col;
                            row_next     = step.row;
                            base_next    = step.base;
                            wr_en_next   = step.wr_en;
                            wr_addr_next = step.wr_addr;
                            wr_data_next = step.wr_data;
                            if (step.scroll)
                            begin
                                scroll_next = 1'b1;
                                ptr_next    = '0;
                                state_next  = S_SWEEP;
                            end
                        end
                        ttce_pkg::ACT_CLEAR:
                        begin
                            col_next    = '0;
                            row_next    = '0;
                            base_next   = '0;
                            scroll_next = 1'b0;
                            ptr_next    = '0;
                            state_next  = S_SWEEP;
                        end
                        ttce_pkg::ACT_READ:
                        begin
                            if (int'(cell_index) < ttce_pkg::CELL_COUNT)
                            begin
                                rd_en         = 1'b1;
                                read_hit_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            read_hit_next = 1'b0;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    cursor_index_next = ttce_pkg::cursor_t'(cursor_sum);
                    cell_data_next    = read_hit_reg ? rd_data : '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            scroll_reg    <= 1'b0;
            wr_en_reg     <= 1'b0;
            wr_copy_reg   <= 1'b0;
            read_hit_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            attr_reg      <= ttce_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            scroll_reg    <= scroll_next;
            wr_en_reg     <= wr_en_next;
            wr_copy_reg   <= wr_copy_next;
            read_hit_reg  <= read_hit_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg      <= wr_addr_next;
        wr_data_reg      <= wr_data_next;
        cursor_index_reg <= cursor_index_next;
        cell_data_reg    <= cell_data_next;
    end

`ifndef ASSERT_OFF
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(col_reg) < ttce_pkg::COLUMNS) && (int'(row_reg) < ttce_pkg::ROWS))
        else $error("cursor left the screen");

    a_row_base_match: assert property (@(posedge clk) disable iff (!rst_n)
        int'(base_reg) == int'(row_reg) * ttce_pkg::COLUMNS)
        else $error("row base out of step with cursor row");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DONE || state_reg == S_SWEEP))
        else $error("accepted transfer not taken into work");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ptr_reg) <= ttce_pkg::CELL_COUNT)
        else $error("sweep pointer past the store");

    a_copy_only_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        wr_copy_reg |-> scroll_reg)
        else $error("cell copy outside a scroll");
`endif

endmodule

`default_nettype wire

[rtl/ttce_cell_store.sv]
`default_nettype none

module ttce_cell_store (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire ttce_pkg::addr_t wr_addr,
    input  wire ttce_pkg::cell_t wr_data,
    input  wire logic            rd_en,
    input  wire ttce_pkg::addr_t rd_addr,
    output ttce_pkg::cell_t      rd_data
);

    ttce_pkg::cell_t mem [ttce_pkg::CELL_COUNT];
    ttce_pkg::cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/ttce_cursor_step.sv]
`default_nettype none

module ttce_cursor_step (
    input  wire ttce_pkg::col_t  col,
    input  wire ttce_pkg::row_t  row,
    input  wire ttce_pkg::addr_t base,
    input  wire ttce_pkg::char_t char_code,
    input  wire ttce_pkg::char_t attr,
    output ttce_pkg::step_t      step
);

    ttce_pkg::wcol_t col_tab;
    ttce_pkg::wcol_t col_inc;
    ttce_pkg::col_t  col_bs;
    ttce_pkg::col_t  wr_col;
    logic            advance;

    always_comb
    begin
        col_tab = (ttce_pkg::wcol_t'(col) + ttce_pkg::wcol_t'(ttce_pkg::TAB_STOP))
                  & ~ttce_pkg::wcol_t'(ttce_pkg::TAB_STOP - 1);
        col_inc = ttce_pkg::wcol_t'(col) + ttce_pkg::wcol_t'(1);
        col_bs  = (col == '0) ? col : col - ttce_pkg::col_t'(1);
        wr_col  = (char_code == ttce_pkg::CH_BS) ? col_bs : col;
        advance = 1'b0;

        step         = '0;
        step.col     = col;
        step.row     = row;
        step.base    = base;
        step.wr_addr = base + ttce_pkg::addr_t'(wr_col);
        step.wr_data = {attr, char_code};

        if (char_code == ttce_pkg::CH_BS)
        begin
            step.col     = col_bs;
            step.wr_en   = 1'b1;
            step.wr_data = {attr, ttce_pkg::CH_SPACE};
        end
        else if (char_code == ttce_pkg::CH_TAB)
        begin
            if (col_tab >= ttce_pkg::wcol_t'(ttce_pkg::COLUMNS))
            begin
                advance = 1'b1;
            end
            else
            begin
                step.col = ttce_pkg::col_t'(col_tab);
            end
        end
        else if (char_code == ttce_pkg::CH_CR)
        begin
            step.col = '0;
        end
        else if (char_code == ttce_pkg::CH_LF)
        begin
            advance = 1'b1;
        end
        else if (char_code >= ttce_pkg::CH_SPACE && char_code <= ttce_pkg::CH_PRINT_MAX)
        begin
            step.wr_en = 1'b1;
            if (col_inc >= ttce_pkg::wcol_t'(ttce_pkg::COLUMNS))
            begin
                advance = 1'b1;
            end
            else
            begin
                step.col = ttce_pkg::col_t'(col_inc);
            end
        end

        if (advance)
        begin
            step.col = '0;
            if (row == ttce_pkg::row_t'(ttce_pkg::ROWS - 1))
            begin
                step.scroll = 1'b1;
            end
            else
            begin
                step.row  = row + ttce_pkg::row_t'(1);
                step.base = base + ttce_pkg::addr_t'(ttce_pkg::COLUMNS);
            end
        end
    end

endmodule

`default_nettype wire

[tb/text_terminal_char_engine_unit_tb.sv]
module text_terminal_char_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttce_pkg::*;

    localparam int      WATCHDOG_LIMIT = 20000;
    localparam int      HOLD_CYCLES    = 400;
    localparam int      MAX_REPORTS    = 10;
    localparam action_t ACT_UNUSED     = 2'd3;

    typedef struct packed {
        cursor_t cursor;
        cell_t   data;
    } console_result_t;

    logic    clk;
    logic    rst_n       = 1'b0;
    logic    cfg_wr_en   = 1'b0;
    char_t   cfg_wr_data = '0;
    logic    in_valid    = 1'b0;
    logic    in_stall;
    action_t action      = ACT_PUT;
    char_t   char_code   = '0;
    index_t  cell_index  = '0;
    logic    out_valid;
    logic    out_stall   = 1'b0;
    cursor_t cursor_index;
    cell_t   cell_data;

    cell_t screen_image [CELL_COUNT];
    int    cur_col;
    int    cur_row;
    char_t text_attr;

    console_result_t pending_results [$];

    int mismatches  = 0;
    int checked     = 0;
    int sent        = 0;
    int scrolls     = 0;
    int clears      = 0;
    int reads       = 0;
    int attr_writes = 0;
    int idle_cycles = 0;
    bit sender_pauses = 1'b1;
    bit hold_start    = 1'b0;

    text_terminal_char_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_index (cursor_index),
        .cell_data    (cell_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // console model

    function automatic cell_t blank_cell();
        return {text_attr, CH_SPACE};
    endfunction

    function automatic void blank_screen();
        foreach (screen_image[i])
        begin
            screen_image[i] = blank_cell();
        end
    endfunction

    function automatic void next_line();
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < MOVE_COUNT; i++)
            begin
                screen_image[i] = screen_image[i + COLUMNS];
            end
            for (int i = MOVE_COUNT; i < CELL_COUNT; i++)
            begin
                screen_image[i] = blank_cell();
            end
            cur_row = ROWS - 1;
            scrolls++;
        end
    endfunction

    function automatic void interpret_char(char_t c);
        if (c == CH_BS)
        begin
            if (cur_col > 0)
                cur_col--;
            screen_image[cur_row * COLUMNS + cur_col] = blank_cell();
        end
        else if (c == CH_TAB)
        begin
            cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
        end
        else if (c == CH_CR)
        begin
            cur_col = 0;
        end
        else if (c == CH_LF)
        begin
            cur_col = 0;
            next_line();
        end
        else if (c >= CH_SPACE && c <= CH_PRINT_MAX)
        begin
            screen_image[cur_row * COLUMNS + cur_col] = {text_attr, c};
            cur_col++;
        end
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            next_line();
        end
    endfunction

    function automatic console_result_t predict_console(action_t a, char_t c, index_t idx);
        console_result_t r;
        r.data = '0;
        case (a)
            ACT_PUT:
            begin
                interpret_char(c);
            end
            ACT_CLEAR:
            begin
                blank_screen();
                cur_col = 0;
                cur_row = 0;
                clears++;
            end
            ACT_READ:
            begin
                reads++;
                if (idx < CELL_COUNT)
                    r.data = screen_image[idx];
            end
            default:
            begin
            end
        endcase
        r.cursor = cursor_t'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender side

    task automatic send_item(action_t a, char_t c, index_t idx);
        int gap;
        action     <= a;
        char_code  <= c;
        cell_index <= idx;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_console(a, c, idx));
        sent++;
        gap = sender_pauses ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_char(char_t c);
        send_item(ACT_PUT, c, index_t'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(int idx);
        send_item(ACT_READ, char_t'($urandom_range(0, 255)), index_t'(idx));
    endtask

    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(char_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        text_attr = v;
        attr_writes++;
        @(posedge clk);
    endtask

    task automatic send_random_item();
        int roll;
        int here;
        int back;
        roll = $urandom_range(0, 99);
        here = cur_row * COLUMNS + cur_col;
        if (roll < 52)
        begin
            put_char(char_t'($urandom_range(CH_SPACE, CH_PRINT_MAX)));
        end
        else if (roll < 61)
        begin
            case ($urandom_range(0, 3))
                0: put_char(CH_LF);
                1: put_char(CH_CR);
                2: put_char(CH_TAB);
                default: put_char(CH_BS);
            endcase
        end
        else if (roll < 66)
        begin
            put_char(char_t'($urandom_range(0, 255)));
        end
        else if (roll < 94)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                read_cell($urandom_range(0, 2047));
            end
            else
            begin
                back = $urandom_range(0, 100);
                read_cell(here > back ? here - back : 0);
            end
        end
        else if (roll < 95)
        begin
            send_item(ACT_CLEAR, char_t'($urandom_range(0, 255)),
                      index_t'($urandom_range(0, 2047)));
        end
        else if (roll < 97)
        begin
            send_item(ACT_UNUSED, char_t'($urandom_range(0, 255)),
                      index_t'($urandom_range(0, 2047)));
        end
        else
        begin
            put_char(char_t'($urandom_range(CH_SPACE, CH_PRINT_MAX)));
        end
    endtask

    // tests

    task automatic test_reset_image();
        read_cell(0);
        read_cell(1);
        read_cell(1024);
        read_cell(CELL_COUNT - 1);
        read_cell(CELL_COUNT);
        read_cell(2047);
    endtask

    task automatic test_control_codes();
        put_char(8'h41);
        put_char(CH_PRINT_MAX);
        put_char(CH_SPACE);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h1F);
        put_char(CH_TAB);
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_LF);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        send_item(ACT_UNUSED, 8'hAA, 11'h555);
        send_item(ACT_CLEAR, 8'h55, 11'h2AA);
        // backspace with the cursor already at column 0
        put_char(CH_BS);
        read_cell(0);
        send_item(ACT_UNUSED, 8'h00, 11'h000);
    endtask

    task automatic test_wrap_and_scroll();
        send_item(ACT_CLEAR, 8'h00, 11'h000);
        for (int i = 0; i < COLUMNS; i++)
            put_char(char_t'(8'h30 + (i % 40)));
        for (int i = 0; i < COLUMNS / TAB_STOP; i++)
            put_char(CH_TAB);
        for (int i = 0; i < ROWS - 3; i++)
            put_char(CH_LF);
        for (int i = 0; i < 20; i++)
            put_char(char_t'(8'h61 + (i % 26)));
        // line feeds on the bottom row scroll the screen
        put_char(CH_LF);
        put_char(CH_LF);
        for (int i = 0; i < COLUMNS; i++)
            put_char(char_t'(8'h41 + (i % 26)));
        put_char(CH_BS);
        for (int i = 0; i < 4; i++)
        begin
            read_cell((ROWS - 2) * COLUMNS + i);
            read_cell((ROWS - 4) * COLUMNS + i);
            read_cell((ROWS - 1) * COLUMNS + i);
        end
        for (int i = 0; i < 5; i++)
            put_char(char_t'(8'h21 + i));
        put_char(CH_CR);
        put_char(CH_BS);
        read_cell((ROWS - 1) * COLUMNS);
    endtask

    task automatic test_attribute_extremes();
        char_t settings [3];
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = char_t'($urandom_range(1, 254));
        foreach (settings[k])
        begin
            drain();
            write_attribute(settings[k]);
            put_char(8'h5A);
            put_char(CH_BS);
            put_char(8'h7E);
            read_cell(cur_row * COLUMNS + cur_col - 1);
            read_cell(cur_row * COLUMNS + cur_col);
            send_item(ACT_CLEAR, 8'h00, 11'h000);
            read_cell(CELL_COUNT - 1);
            put_char(CH_PRINT_MAX);
            read_cell(0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_start    = 1'b1;
        sender_pauses = 1'b0;
        for (int i = 0; i < 40; i++)
            send_random_item();
        sender_pauses = 1'b1;
        drain();
    endtask

    task automatic test_random_text();
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: write_attribute(8'h00);
                7: write_attribute(8'hFF);
                default: write_attribute(char_t'($urandom_range(0, 255)));
            endcase
            sender_pauses = (phase % 3) != 1;
            for (int i = 0; i < 34; i++)
                send_random_item();
        end
        sender_pauses = 1'b1;
    endtask

    // receiver side: random stall with calm stretches and an occasional long hold

    initial
    begin
        int   stall_left;
        int   stretch_left;
        int   hold_left;
        bit   calm;
        logic nxt;
        stall_left   = 0;
        stretch_left = 0;
        hold_left    = 0;
        calm         = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b1;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    calm         = ($urandom_range(0, 3) == 0);
                    stretch_left = $urandom_range(50, 300);
                end
                stretch_left--;
                nxt = 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 2);
                    nxt = 1'b1;
                end
            end
            out_stall <= nxt;
        end
    end

    // result check

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: cursor %0d data %h",
                             cursor_index, cell_data);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (cursor_index !== want.cursor || cell_data !== want.data)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: cursor exp %0d got %0d, data exp %h got %h",
                                 checked, want.cursor, cursor_index, want.data, cell_data);
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        text_attr = RESET_ATTR;
        blank_screen();
        cur_col = 0;
        cur_row = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_image();
        test_control_codes();
        test_wrap_and_scroll();
        test_attribute_extremes();
        test_backpressure();
        test_random_text();
        drain();

        $display("covered %0d transfers (%0d reads, %0d clears, %0d scrolls), %0d checked",
                 sent, reads, clears, scrolls, checked);
        $display("attribute written %0d times, %0d mismatches", attr_writes, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
